[sv/command_rate_regulator_defines.svh]
// Assertion helpers used by the regulator controller (crr_ctrl).
`ifndef COMMAND_RATE_REGULATOR_DEFINES_SVH
`define COMMAND_RATE_REGULATOR_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define CRR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// Check that a condition holds in the cycle after a trigger.
`define CRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence check violated");

`endif

[sv/crr_pkg.sv]
package crr_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MODE = 2'd1;

    localparam logic [31:0] MIN_PERIOD_RST  = 32'd1000;
    localparam logic        LEADER_MODE_RST = 1'b1;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_MSG  = 1'b1;

    localparam logic STATUS_DELIVERED = 1'b0;
    localparam logic STATUS_DROPPED   = 1'b1;

    typedef struct packed {
        logic        func;
        logic [7:0]  message_id;
        logic [7:0]  command_kind;
        logic [31:0] command_arg;
    } t_crr_in;

    typedef struct packed {
        logic        status;
        logic [7:0]  out_id;
        logic [7:0]  out_kind;
        logic [31:0] out_arg;
        logic        from_queue;
    } t_crr_out;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  kind;
        logic [31:0] arg;
    } t_crr_entry;

    // Per-word decision handed from the controller to the datapath.
    typedef struct packed {
        logic emit;
        logic status;
        logic from_queue;
        logic rd_en;
        logic wr_en;
    } t_crr_ctl;

endpackage

[sv/crr_store.sv]
module crr_store #(
    parameter int unsigned DEPTH  = 8,
    parameter int unsigned ADDR_W = 3
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  crr_pkg::t_crr_entry i_wdata,
    input  logic                i_re,
    input  logic [ADDR_W-1:0]   i_raddr,
    output crr_pkg::t_crr_entry o_rdata
);
    import crr_pkg::*;

    t_crr_entry r_mem [DEPTH];
    t_crr_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; hold the last word until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/crr_ctrl.sv]
`include "command_rate_regulator_defines.svh"

module crr_ctrl #(
    parameter int unsigned DEPTH  = 8,
    parameter int unsigned ADDR_W = 3,
    parameter int unsigned CNT_W  = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [crr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [crr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_accept,
    input  logic                           i_func,
    output crr_pkg::t_crr_ctl              o_ctl,
    output logic [ADDR_W-1:0]              o_rd_addr,
    output logic [ADDR_W-1:0]              o_wr_addr
);
    import crr_pkg::*;

    logic [31:0]       r_min_period;
    logic              r_leader_mode;
    logic [31:0]       r_time;
    logic [31:0]       r_last;
    logic [31:0]       r_head;
    logic [ADDR_W-1:0] r_wslot;
    logic [ADDR_W-1:0] r_rslot;
    logic [CNT_W-1:0]  r_count;

    logic [31:0]       n_time;
    logic [31:0]       n_last;
    logic [31:0]       n_head;
    logic [ADDR_W-1:0] n_wslot;
    logic [ADDR_W-1:0] n_rslot;
    logic [CNT_W-1:0]  n_count;

    logic [31:0] time_inc;
    logic [31:0] target;
    logic [31:0] tick_diff;
    logic [31:0] msg_diff;
    logic        deq;
    logic        direct;
    logic        full;
    t_crr_ctl    ctl;

    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] s);
        next_slot = (s == ADDR_W'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period  <= MIN_PERIOD_RST;
            r_leader_mode <= LEADER_MODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_PERIOD:  r_min_period  <= i_cfg_data;
                CFG_LEADER_MODE: r_leader_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Reached means the wrapped difference is below half the time range.
    assign time_inc  = r_time + 32'd1;
    assign target    = r_last + r_min_period;
    assign tick_diff = time_inc - r_head;
    assign msg_diff  = r_time - target;
    assign deq       = (r_count != '0) && !tick_diff[31];
    assign direct    = !msg_diff[31];
    assign full      = (r_count == CNT_W'(DEPTH));

    always_comb begin
        n_time  = r_time;
        n_last  = r_last;
        n_head  = r_head;
        n_wslot = r_wslot;
        n_rslot = r_rslot;
        n_count = r_count;
        ctl     = '0;
        if (i_accept) begin
            if (i_func == FUNC_TICK) begin
                n_time = time_inc;
                if (deq) begin
                    ctl.emit       = 1'b1;
                    ctl.status     = STATUS_DELIVERED;
                    ctl.from_queue = 1'b1;
                    ctl.rd_en      = 1'b1;
                    n_rslot        = next_slot(r_rslot);
                    n_count        = r_count - 1'b1;
                    if (r_count != CNT_W'(1)) begin
                        n_head = r_head + r_min_period;
                    end
                end
            end else if (!r_leader_mode) begin
                if (direct) begin
                    ctl.emit   = 1'b1;
                    ctl.status = STATUS_DELIVERED;
                    n_last     = r_time;
                end else if (full) begin
                    ctl.emit   = 1'b1;
                    ctl.status = STATUS_DROPPED;
                end else begin
                    ctl.wr_en = 1'b1;
                    n_wslot   = next_slot(r_wslot);
                    n_last    = target;
                    n_count   = r_count + 1'b1;
                    if (r_count == '0) begin
                        n_head = target;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time  <= '0;
            r_last  <= '0;
            r_head  <= '0;
            r_wslot <= '0;
            r_rslot <= '0;
            r_count <= '0;
        end else begin
            r_time  <= n_time;
            r_last  <= n_last;
            r_head  <= n_head;
            r_wslot <= n_wslot;
            r_rslot <= n_rslot;
            r_count <= n_count;
        end
    end

    assign o_ctl     = ctl;
    assign o_rd_addr = r_rslot;
    assign o_wr_addr = r_wslot;

    `CRR_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `CRR_ASSERT_ALWAYS(a_one_port_op, i_clk, i_rst_n, !(ctl.rd_en && ctl.wr_en))
    `CRR_ASSERT_NEXT(a_deq_count, i_clk, i_rst_n, ctl.rd_en, r_count + 1'b1 == $past(r_count))
    `CRR_ASSERT_NEXT(a_enq_count, i_clk, i_rst_n, ctl.wr_en, r_count == $past(r_count) + 1'b1)

endmodule

[sv/command_rate_regulator.sv]
// Results pass the decision stage and output register. Throughput: one word per cycle
// unless back-pressure drops o_in_ready; each word does one read-modify-write of the
// time/queue registers and at most one access to the single-port-per-direction store.
// Reset: synchronous, active low; clears time, queue pointers, count and pipeline valids,
// and loads min_period = 1000, leader_mode = 1. Store contents stay undefined (no sweep).
module command_rate_regulator #(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [crr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [crr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  crr_pkg::t_crr_in               i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output crr_pkg::t_crr_out              o_out_data
);
    import crr_pkg::*;

    localparam int unsigned ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);

    logic              accept;
    t_crr_ctl          ctl;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    t_crr_entry        wdata;
    t_crr_entry        rdata;

    // Decision stage: holds the verdict while the store read completes.
    logic       r_p_valid;
    logic       r_p_status;
    logic       r_p_from_queue;
    t_crr_entry r_p_entry;

    // Output word register.
    logic     r_o_valid;
    t_crr_out r_o_data;

    logic     p_move;
    t_crr_out n_o_data;

    // Advance the decision stage whenever the output register is free or draining.
    assign p_move     = r_p_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_p_valid || p_move;
    assign accept     = i_in_valid && o_in_ready;

    assign wdata.id   = i_in_data.message_id;
    assign wdata.kind = i_in_data.command_kind;
    assign wdata.arg  = i_in_data.command_arg;

    crr_ctrl #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_func     (i_in_data.func),
        .o_ctl      (ctl),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr)
    );

    // An entry is always written at least one word before it is read, so the
    // registered read never races its own write.
    crr_store #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ctl.wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wdata),
        .i_re    (ctl.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (accept) begin
            r_p_valid <= ctl.emit;
        end else if (p_move) begin
            r_p_valid <= 1'b0;
        end
    end

    // Hold the direct-path fields alongside the verdict.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_status     <= ctl.status;
            r_p_from_queue <= ctl.from_queue;
            r_p_entry      <= wdata;
        end
    end

    // Pick queue data from the store read or the held direct word.
    always_comb begin
        if (r_p_from_queue) begin
            n_o_data.status     = STATUS_DELIVERED;
            n_o_data.out_id     = rdata.id;
            n_o_data.out_kind   = rdata.kind;
            n_o_data.out_arg    = rdata.arg;
            n_o_data.from_queue = 1'b1;
        end else begin
            n_o_data.status     = r_p_status;
            n_o_data.out_id     = r_p_entry.id;
            n_o_data.out_kind   = r_p_entry.kind;
            n_o_data.out_arg    = r_p_entry.arg;
            n_o_data.from_queue = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p_move) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_move) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule
